// ----- rtl/core/hcordic_pkg.sv -----
`timescale 1ns / 1ps

package hcordic_pkg;

	localparam int DATA_W         = 16;
	localparam int ITERATIONS_DEF = 12;
	localparam int ITERATIONS_MAX = 15;

	localparam logic [DATA_W-1:0] CORDIC_GAIN = 16'h1351;

	// truncated atanh(2^-i) in 3.12, entry i-1
	localparam logic [DATA_W-1:0] ATANH_TAB [0:ITERATIONS_MAX-1] = '{
		16'h08C9, 16'h0416, 16'h0202, 16'h0100, 16'h0080, 16'h0040, 16'h0020, 16'h0010,
		16'h0008, 16'h0004, 16'h0002, 16'h0001, 16'h0000, 16'h0000, 16'h0000
	};

	typedef struct packed {
		logic [DATA_W-1:0] x;
		logic [DATA_W-1:0] y;
		logic [DATA_W-1:0] z;
	} hcordic_data_t;

	function automatic bit is_repeat(input int i);
		return (i == 4) || (i == 7) || (i == 10) || (i == 13);
	endfunction

	// number of micro-steps for a given iteration count
	function automatic int num_steps(input int iters);
		int cnt;
		cnt = 0;
		for (int i = 1; i <= ITERATIONS_MAX; i++) begin
			if (i <= iters) begin
				cnt = cnt + 1;
				if (is_repeat(i))
					cnt = cnt + 1;
			end
		end
		return cnt;
	endfunction

	// shift amount used by micro-step k (0 based)
	function automatic int step_shift(input int k);
		int cnt;
		int res;
		cnt = 0;
		res = 1;
		for (int i = 1; i <= ITERATIONS_MAX; i++) begin
			if (cnt == k)
				res = i;
			cnt = cnt + 1;
			if (is_repeat(i)) begin
				if (cnt == k)
					res = i;
				cnt = cnt + 1;
			end
		end
		return res;
	endfunction

endpackage

// ----- rtl/core/hcordic_in_if.sv -----
`timescale 1ns / 1ps

interface hcordic_in_if
	import hcordic_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] angle;

	modport source (output valid, output angle, input ready);
	modport sink   (input valid, input angle, output ready);
endinterface

// ----- rtl/core/hcordic_out_if.sv -----
`timescale 1ns / 1ps

interface hcordic_out_if
	import hcordic_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] cosh_value;
	logic signed [DATA_W-1:0] sinh_value;

	modport source (output valid, output cosh_value, output sinh_value, input ready);
	modport sink   (input valid, input cosh_value, input sinh_value, output ready);
endinterface

// ----- rtl/core/hcordic_stage.sv -----
`timescale 1ns / 1ps

module hcordic_stage
	import hcordic_pkg::*;
#(
	parameter int SHIFT = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  hcordic_data_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output hcordic_data_t out_data
);

	localparam logic [DATA_W-1:0] ATANH = ATANH_TAB[SHIFT-1];

	logic          valid_s1;
	hcordic_data_t data_s1;
	hcordic_data_t step;
	logic [DATA_W-1:0] xs;
	logic [DATA_W-1:0] ys;

	always_comb begin
		xs = $unsigned($signed(in_data.x) >>> SHIFT);
		ys = $unsigned($signed(in_data.y) >>> SHIFT);
		// zero residual counts as non-negative
		if (in_data.z[DATA_W-1]) begin
			step.x = in_data.x - ys;
			step.y = in_data.y - xs;
			step.z = in_data.z + ATANH;
		end else begin
			step.x = in_data.x + ys;
			step.y = in_data.y + xs;
			step.z = in_data.z - ATANH;
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= step;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

// ----- rtl/core/hyperbolic_cordic_cosh_sinh_top.sv -----
`timescale 1ns / 1ps
// Hyperbolic CORDIC, rotation mode: cosh and sinh of a 3.12 angle.
// Pipeline: one register stage per micro-step, ITERATIONS plus the repeated
// iterations (4, 7, 10, 13) that fall within ITERATIONS.
// Throughput: one transaction per cycle; each stage holds under back-pressure.
// Reset clears the stage valid bits only; data registers are not reset.

module hyperbolic_cordic_cosh_sinh_top
	import hcordic_pkg::*;
#(
	parameter int ITERATIONS = ITERATIONS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	hcordic_in_if.sink     in_ch,
	hcordic_out_if.source  out_ch
);

	localparam int NSTEPS = num_steps(ITERATIONS);

	logic          valid [0:NSTEPS];
	logic          ready [0:NSTEPS];
	hcordic_data_t data  [0:NSTEPS];

	assign valid[0]     = in_ch.valid;
	assign in_ch.ready  = ready[0];
	assign data[0].x    = CORDIC_GAIN;
	assign data[0].y    = '0;
	assign data[0].z    = $unsigned(in_ch.angle);

	for (genvar k = 0; k < NSTEPS; k++) begin : g_step
		hcordic_stage #(
			.SHIFT (step_shift(k))
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid[k]),
			.in_ready  (ready[k]),
			.in_data   (data[k]),
			.out_valid (valid[k+1]),
			.out_ready (ready[k+1]),
			.out_data  (data[k+1])
		);
	end

	assign out_ch.valid      = valid[NSTEPS];
	assign ready[NSTEPS]     = out_ch.ready;
	assign out_ch.cosh_value = $signed(data[NSTEPS].x);
	assign out_ch.sinh_value = $signed(data[NSTEPS].y);

endmodule
